// ----- rtl/qie_pkg.sv -----
// Shared constants for the QUBO / Ising energy evaluator: field layout, codes and defaults.
package qie_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_VARS_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed field widths of the stream payloads.
	localparam int OP_W       = 2;
	localparam int ROW_W      = 6;
	localparam int COL_W      = 6;
	localparam int VALUE_W    = 32;
	localparam int SOL_W      = 64;
	localparam int ENERGY_W   = 48;
	localparam int SIZE_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Bit positions of the fields inside the slave-side tdata.
	localparam int ROW_LSB   = 0;
	localparam int COL_LSB   = ROW_LSB + ROW_W;
	localparam int VALUE_LSB = COL_LSB + COL_W;
	localparam int SOL_LSB   = VALUE_LSB + VALUE_W;
	localparam int S_FIELDS_W = SOL_LSB + SOL_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((ENERGY_W + 7) / 8) * 8;

	// Operation codes carried in tuser.
	localparam logic [OP_W-1:0] OP_WRITE_WEIGHT = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE_BIAS   = 2'd1;
	localparam logic [OP_W-1:0] OP_EVALUATE     = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

	// Reset value of the size configuration register.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

endpackage

// ----- rtl/qubo_ising_energy_eval.sv -----
// Top level of the QUBO / Ising energy evaluator: weight and bias memories and the sweep engine.
//
// The block stores a MAX_VARS x MAX_VARS weight matrix and a MAX_VARS-entry bias vector, both
// loaded through the input stream one entry per request (tuser selects write weight, write bias
// or evaluate), and on an evaluate request returns the energy of the carried solution over the
// first N = size_in_use variables (saturated to MAX_VARS). In QUBO mode the energy is the sum of
// W[i][j] over all pairs with both bits set; in Ising mode bits map to spins of +1 and -1 and the
// energy is offset + sum of h[i]*q[i] + sum of J[i][j]*q[i]*q[j], diagonal included. Values are
// Q16.16 and the 48-bit result is exact. Memory contents are undefined until written, so every
// entry that an evaluation will touch must be loaded first. An evaluation sweeps the weight
// memory one word per cycle through its single read port, then passes a drain state and a
// merge state that loads the result; no new request is taken until it is back in idle. With
// N = 0 it goes straight to the merge state. Results sit in an output register, so write
// requests are still taken while a result waits; an evaluation whose result finds that
// register still full waits there before finishing. Configuration must only be written while
// no evaluation is in progress.
module qubo_ising_energy_eval #(
	parameter int MAX_VARS   = qie_pkg::MAX_VARS_DEF,
	parameter int VALUE_BITS = qie_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [qie_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qie_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Request stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// From bit 0: row[5:0], col[11:6], value[43:12], solution_bits[107:44], zero fill.
	input  logic [qie_pkg::S_TDATA_W-1:0]   s_tdata,
	// From bit 0: operation[1:0].
	input  logic [qie_pkg::OP_W-1:0]        s_tuser,
	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// From bit 0: energy[47:0].
	output logic [qie_pkg::M_TDATA_W-1:0]   m_tdata
);
	import qie_pkg::*;

	localparam int IDX_W  = $clog2(MAX_VARS);
	localparam int WDEPTH = (1 << IDX_W) * (1 << IDX_W);
	localparam int BDEPTH = 1 << IDX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_MERGE
	} state_t;

	// Configuration registers.
	logic                  mode_q;
	logic [SIZE_W-1:0]     size_q;
	logic [VALUE_W-1:0]    offset_q;

	// Memories.
	logic [VALUE_BITS-1:0] wmem [WDEPTH];
	logic [VALUE_BITS-1:0] bmem [BDEPTH];

	// Request fields.
	logic                  accept;
	logic [ROW_W-1:0]      req_row;
	logic [COL_W-1:0]      req_col;
	logic [VALUE_W-1:0]    req_value;
	logic [SOL_W-1:0]      req_sol;
	logic                  row_ok;
	logic                  col_ok;
	logic                  w_we;
	logic                  b_we;

	// Sweep control.
	state_t                state_q;
	logic [IDX_W-1:0]      i_q;
	logic [IDX_W-1:0]      j_q;
	logic [IDX_W-1:0]      nm1_q;
	logic [MAX_VARS-1:0]   sol_q;
	logic                  ising_q;
	logic [SIZE_W-1:0]     n_sat;
	logic [SIZE_W-1:0]     n_m1;
	logic                  issue;
	logic                  last_issue;

	// Read stage.
	logic                  vld_s1;
	logic                  qi_s1;
	logic                  qj_s1;
	logic                  first_s1;
	logic [VALUE_BITS-1:0] wdata_s1;
	logic [VALUE_BITS-1:0] bdata_s1;
	logic [ENERGY_W-1:0]   w_ext;
	logic [ENERGY_W-1:0]   b_ext;

	// Accumulators and result.
	logic [ENERGY_W-1:0]   acc_q;
	logic [ENERGY_W-1:0]   bacc_q;
	logic                  m_tvalid_q;
	logic [ENERGY_W-1:0]   energy_q;
	logic                  out_free;

	assign req_row   = s_tdata[ROW_LSB +: ROW_W];
	assign req_col   = s_tdata[COL_LSB +: COL_W];
	assign req_value = s_tdata[VALUE_LSB +: VALUE_W];
	assign req_sol   = s_tdata[SOL_LSB +: SOL_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Writes beyond the MAX_VARS x MAX_VARS matrix are dropped.
	assign row_ok = ({1'b0, req_row} < SIZE_W'(MAX_VARS));
	assign col_ok = ({1'b0, req_col} < SIZE_W'(MAX_VARS));
	assign w_we   = accept && (s_tuser == OP_WRITE_WEIGHT) && row_ok && col_ok;
	assign b_we   = accept && (s_tuser == OP_WRITE_BIAS) && row_ok;

	// Number of variables in use, saturated to the matrix size.
	assign n_sat = (size_q > SIZE_W'(MAX_VARS)) ? SIZE_W'(MAX_VARS) : size_q;
	assign n_m1  = n_sat - SIZE_W'(1);

	assign issue      = (state_q == ST_RUN);
	assign last_issue = issue && (i_q == nm1_q) && (j_q == nm1_q);
	assign out_free   = !m_tvalid_q || m_tready;

	// Weight memory: written by load requests, read one word per cycle during a sweep.
	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[{req_row[IDX_W-1:0], req_col[IDX_W-1:0]}] <= req_value[VALUE_BITS-1:0];
		end
		if (issue) begin
			wdata_s1 <= wmem[{i_q, j_q}];
		end
	end

	// Bias memory: the entry of the current row is read alongside every weight word.
	always_ff @(posedge clk) begin
		if (b_we) begin
			bmem[req_row[IDX_W-1:0]] <= req_value[VALUE_BITS-1:0];
		end
		if (issue) begin
			bdata_s1 <= bmem[i_q];
		end
	end

	// Spin flags travel alongside the read so they line up with the returned data.
	always_ff @(posedge clk) begin
		if (issue) begin
			qi_s1    <= sol_q[i_q];
			qj_s1    <= sol_q[j_q];
			first_s1 <= (j_q == '0);
		end
	end

	assign w_ext = {{(ENERGY_W - VALUE_BITS){wdata_s1[VALUE_BITS-1]}}, wdata_s1};
	assign b_ext = {{(ENERGY_W - VALUE_BITS){bdata_s1[VALUE_BITS-1]}}, bdata_s1};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			size_q   <= SIZE_RESET;
			offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[0];
				CFG_SIZE:   size_q   <= cfg_data[SIZE_W-1:0];
				CFG_OFFSET: offset_q <= cfg_data[VALUE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sweep sequencer, accumulators and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			i_q        <= '0;
			j_q        <= '0;
			nm1_q      <= '0;
			sol_q      <= '0;
			ising_q    <= 1'b0;
			vld_s1     <= 1'b0;
			acc_q      <= '0;
			bacc_q     <= '0;
			m_tvalid_q <= 1'b0;
			energy_q   <= '0;
		end else begin
			vld_s1 <= issue;

			// In the merge state the output register is loaded below instead.
			if (m_tvalid_q && m_tready && (state_q != ST_MERGE)) begin
				m_tvalid_q <= 1'b0;
			end

			// The weight term adds when both variables are set (QUBO) or the spins agree
			// (Ising), and subtracts on disagreeing spins.
			if (vld_s1) begin
				if (ising_q) begin
					acc_q <= (qi_s1 == qj_s1) ? (acc_q + w_ext) : (acc_q - w_ext);
					if (first_s1) begin
						bacc_q <= qi_s1 ? (bacc_q + b_ext) : (bacc_q - b_ext);
					end
				end else if (qi_s1 && qj_s1) begin
					acc_q <= acc_q + w_ext;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && (s_tuser == OP_EVALUATE)) begin
						i_q     <= '0;
						j_q     <= '0;
						nm1_q   <= n_m1[IDX_W-1:0];
						sol_q   <= req_sol[MAX_VARS-1:0];
						ising_q <= mode_q;
						acc_q   <= mode_q ?
							{{(ENERGY_W - VALUE_W){offset_q[VALUE_W-1]}}, offset_q} : '0;
						bacc_q  <= '0;
						state_q <= (n_sat == '0) ? ST_MERGE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end else if (j_q == nm1_q) begin
						j_q <= '0;
						i_q <= i_q + IDX_W'(1);
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (out_free) begin
						energy_q   <= acc_q + bacc_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(energy_q);

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the QUBO / Ising energy evaluator: load, evaluate and compare.
`timescale 1ns / 100ps

module tb;
	import qie_pkg::*;

	// The block is built at its default size; the predictor follows the same numbers.
	localparam int N_VARS = MAX_VARS_DEF;
	localparam int VBITS = VALUE_BITS_DEF;

	// Only the top-left corner of the matrix and the start of the bias vector are loaded,
	// and every evaluation stays inside that corner.
	localparam int LIVE_VARS = 8;

	// Operation code that the block must ignore, and the register index that has no register.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// Energy modes as held in the mode register.
	localparam logic MODE_QUBO = 1'b0;
	localparam logic MODE_ISING = 1'b1;

	// Cycles allowed for the block to go quiet after its last result, and the bound on a drain.
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_LIMIT = 300000;

	// One request as the sender holds it before it goes on the bus. A request with
	// hold_for_results set is only offered once every outstanding energy has come back.
	typedef struct {
		logic [OP_W-1:0]    op;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [VALUE_W-1:0] value;
		logic [SOL_W-1:0]   sol;
		bit                 hold_for_results;
	} request_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;

	// Requests waiting to be driven, and energies predicted for accepted evaluations.
	request_t                pending [$];
	logic [ENERGY_W-1:0]     energy_due [$];

	// Shadow copy of the block's stores and configuration, updated as requests are accepted.
	logic signed [VALUE_W-1:0] weight_copy [0:N_VARS*N_VARS-1];
	logic signed [VALUE_W-1:0] bias_copy [0:N_VARS-1];
	logic                      mode_q;
	logic [SIZE_W-1:0]         size_q;
	logic signed [31:0]        offset_q;

	logic        req_taken;
	int unsigned mismatches;
	int unsigned weight_loads, bias_loads, evaluations, ising_evaluations, ignored_requests;
	int unsigned phases;

	// Sender burst and gap state, and receiver stall state.
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned stall_style = 0;
	int unsigned style_left = 0;
	int unsigned stall_left = 0;

	qubo_ising_energy_eval #(
		.MAX_VARS   (N_VARS),
		.VALUE_BITS (VBITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Energy of a solution under the current shadow configuration. Every term is a plain
	// add or subtract of a stored Q16.16 word, so a 64-bit accumulator is exact; the
	// block returns the low 48 bits.
	function automatic logic [ENERGY_W-1:0] predicted_energy(input logic [SOL_W-1:0] sol);
		int     n;
		longint acc;
		n = (size_q > N_VARS) ? N_VARS : int'(size_q);
		acc = 0;
		if (mode_q == MODE_ISING) begin
			// Bit 1 is spin +1 and bit 0 is spin -1: a bias adds with the sign of its
			// spin, and a coupling adds when both spins agree and subtracts otherwise.
			acc = offset_q;
			for (int i = 0; i < n; i++) begin
				acc += sol[i] ? longint'(bias_copy[i]) : -longint'(bias_copy[i]);
				for (int j = 0; j < n; j++)
					acc += (sol[i] == sol[j]) ? longint'(weight_copy[i*N_VARS+j])
						: -longint'(weight_copy[i*N_VARS+j]);
			end
		end else begin
			// QUBO: only pairs with both variables set contribute.
			for (int i = 0; i < n; i++) begin
				if (sol[i]) begin
					for (int j = 0; j < n; j++)
						if (sol[j])
							acc += longint'(weight_copy[i*N_VARS+j]);
				end
			end
		end
		return acc[ENERGY_W-1:0];
	endfunction

	// Random Q16.16 word with the extremes and zero turning up often.
	function automatic logic [VALUE_W-1:0] rand_q16();
		case ($urandom_range(0, 15))
			0: begin
				return 32'h7FFF_FFFF;
			end
			1: begin
				return 32'h8000_0000;
			end
			2: begin
				return 32'h0000_0000;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// All sampling happens at the rising edge, before the block's own updates land.
	// Configuration writes are copied first, then results are checked, then the request
	// accepted, if any, updates the shadow stores and, for an evaluation, records its energy.
	always @(posedge clk) begin
		logic [ENERGY_W-1:0]       want;
		logic [ROW_W-1:0]          r;
		logic [COL_W-1:0]          c;
		logic signed [VALUE_W-1:0] v;
		req_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE: begin
						mode_q = cfg_data[0];
					end
					CFG_SIZE: begin
						size_q = cfg_data[SIZE_W-1:0];
					end
					CFG_OFFSET: begin
						offset_q = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (energy_due.size() == 0) begin
					$display("%0t: energy %h returned with no evaluation outstanding",
						$time, m_tdata[ENERGY_W-1:0]);
					mismatches++;
				end else begin
					want = energy_due.pop_front();
					if (m_tdata[ENERGY_W-1:0] !== want) begin
						$display("%0t: energy mismatch, expected %h, actual %h",
							$time, want, m_tdata[ENERGY_W-1:0]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				r = s_tdata[ROW_LSB +: ROW_W];
				c = s_tdata[COL_LSB +: COL_W];
				// A stored value keeps its low VALUE_BITS bits, sign-extended.
				v = $signed(s_tdata[VALUE_LSB +: VALUE_W] << (VALUE_W - VBITS))
					>>> (VALUE_W - VBITS);
				case (s_tuser)
					OP_WRITE_WEIGHT: begin
						if (r < N_VARS && c < N_VARS)
							weight_copy[r*N_VARS+c] = v;
						weight_loads++;
					end
					OP_WRITE_BIAS: begin
						if (r < N_VARS)
							bias_copy[r] = v;
						bias_loads++;
					end
					OP_EVALUATE: begin
						energy_due.push_back(predicted_energy(s_tdata[SOL_LSB +: SOL_W]));
						evaluations++;
						if (mode_q == MODE_ISING)
							ising_evaluations++;
					end
					default: begin
						ignored_requests++;
					end
				endcase
			end
		end
	end

	// Request driver. It works in bursts of random length separated by random gaps, with
	// the odd long burst with no gaps at all. A request stays on the bus until it is
	// taken; a request marked to wait is held back until every outstanding energy is in.
	always @(negedge clk) begin
		request_t nxt;
		if (arst_n && !(s_tvalid && !req_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending.size() != 0 &&
					!(pending[0].hold_for_results && energy_due.size() != 0)) begin
				nxt = pending.pop_front();
				s_tuser <= nxt.op;
				s_tdata <= {{(S_TDATA_W-S_FIELDS_W){1'b0}}, nxt.sol, nxt.value, nxt.col, nxt.row};
				s_tvalid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver. It keeps each style of its own for a random spell, then picks a new one:
	// always ready, ready at random with a chance of three in four, or ready with occasional long stalls.
	always @(negedge clk) begin
		logic rdy;
		if (style_left == 0) begin
			stall_style = $urandom_range(0, 2);
			style_left = $urandom_range(50, 400);
		end else begin
			style_left--;
		end
		case (stall_style)
			0: begin
				rdy = 1'b1;
			end
			1: begin
				rdy = ($urandom_range(0, 3) != 0);
			end
			default: begin
				if (stall_left != 0) begin
					stall_left--;
					rdy = 1'b0;
				end else begin
					rdy = 1'b1;
					if ($urandom_range(0, 3) == 0)
						stall_left = $urandom_range(5, 40);
				end
			end
		endcase
		m_tready <= rdy;
	end

	task automatic push_request(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [VALUE_W-1:0] value,
			input logic [SOL_W-1:0] sol, input bit hold);
		request_t item;
		item.op = op;
		item.row = row;
		item.col = col;
		item.value = value;
		item.sol = sol;
		item.hold_for_results = hold;
		pending.push_back(item);
	endtask

	// Evaluation request with random content in the fields that it does not use.
	task automatic push_evaluate(input logic [SOL_W-1:0] sol);
		push_request(OP_EVALUATE, ROW_W'($urandom), COL_W'($urandom), $urandom, sol, 1'b0);
	endtask

	// Register write between phases, while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every request has gone and every energy has come back, then give the
	// block a settling wait to finish whatever sweep it may still be on.
	task automatic drain_and_wait();
		int unsigned waited;
		waited = 0;
		while ((pending.size() != 0 || s_tvalid || energy_due.size() != 0) &&
				waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (energy_due.size() != 0) begin
			$display("%0t: %0d expected energies never arrived", $time, energy_due.size());
			mismatches += energy_due.size();
			energy_due.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		phases++;
	endtask

	// Guard against a block that stops answering.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		logic [SIZE_W-1:0] size_sel;
		logic              mode_sel;
		logic [OP_W-1:0]   op;
		logic [SOL_W-1:0]  sol;
		int unsigned       pick, span;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_WRITE_WEIGHT;
		m_tready = 1'b0;
		req_taken = 1'b0;
		mode_q = MODE_QUBO;
		size_q = SIZE_RESET;
		offset_q = '0;
		mismatches = 0;
		weight_loads = 0;
		bias_loads = 0;
		evaluations = 0;
		ising_evaluations = 0;
		ignored_requests = 0;
		phases = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The stores are undefined until written, so the live corner of the matrix and
		// the matching biases are loaded first; no evaluation uses more variables than
		// that. The fields that a write does not use carry random bits.
		for (int r = 0; r < LIVE_VARS; r++)
			for (int c = 0; c < LIVE_VARS; c++)
				push_request(OP_WRITE_WEIGHT, ROW_W'(r), COL_W'(c), rand_q16(),
					{$urandom, $urandom}, 1'b0);
		for (int r = 0; r < LIVE_VARS; r++)
			push_request(OP_WRITE_BIAS, ROW_W'(r), COL_W'($urandom), rand_q16(),
				{$urandom, $urandom}, 1'b0);
		drain_and_wait();

		// Directed part. QUBO over the live corner: all ones, all zeros, then the extreme
		// values at both corners, an ignored operation, an alternating pattern and all ones again.
		write_reg(CFG_MODE, {31'd0, MODE_QUBO});
		write_reg(CFG_SIZE, 32'(LIVE_VARS));
		push_evaluate(64'hFFFF_FFFF_FFFF_FFFF);
		push_evaluate(64'h0000_0000_0000_0000);
		push_request(OP_WRITE_WEIGHT, 6'd0, 6'd0, 32'h7FFF_FFFF, '0, 1'b0);
		push_request(OP_WRITE_WEIGHT, ROW_W'(LIVE_VARS - 1), COL_W'(LIVE_VARS - 1),
			32'h8000_0000, '1, 1'b0);
		push_request(OP_WRITE_BIAS, 6'd0, 6'd63, 32'h7FFF_FFFF, '0, 1'b0);
		push_request(OP_WRITE_BIAS, ROW_W'(LIVE_VARS - 1), 6'd0, 32'h8000_0000, '1, 1'b0);
		push_request(OP_UNUSED, '1, '1, '1, '1, 1'b0);
		push_evaluate(64'hAAAA_AAAA_AAAA_AAAA);
		push_evaluate(64'hFFFF_FFFF_FFFF_FFFF);
		drain_and_wait();

		// Ising over the live corner with the largest offset. The spare register index is
		// written too and must change nothing.
		write_reg(CFG_MODE, {31'd0, MODE_ISING});
		write_reg(CFG_OFFSET, 32'h7FFF_FFFF);
		write_reg(CFG_SPARE, $urandom);
		push_evaluate(64'hFFFF_FFFF_FFFF_FFFF);
		push_evaluate(64'h0000_0000_0000_0000);
		push_evaluate(64'h5555_5555_5555_5555);
		drain_and_wait();

		// Size zero: Ising gives just the offset, here the most negative one.
		write_reg(CFG_SIZE, 32'd0);
		write_reg(CFG_OFFSET, 32'h8000_0000);
		push_evaluate({$urandom, $urandom});
		drain_and_wait();

		// Size zero in QUBO mode gives zero; the upper bits of the write data are junk.
		write_reg(CFG_MODE, 32'hFFFF_FFFE);
		push_evaluate({$urandom, $urandom});
		drain_and_wait();

		// Size one with junk above the size field: only bit 0 of the solution counts.
		write_reg(CFG_SIZE, 32'hFFFF_FF81);
		push_evaluate(64'hFFFF_FFFF_FFFF_FFFE);
		push_evaluate(64'h0000_0000_0000_0001);
		drain_and_wait();

		// Random phases with sizes inside the live corner. A write's row and column each mostly
		// fall inside the part of the matrix in use so that they move the energies that follow.
		// Part-way through each phase the sender waits for every outstanding energy before going on.
		for (int ph = 0; ph < 4; ph++) begin
			mode_sel = 1'($urandom_range(0, 1));
			size_sel = SIZE_W'($urandom_range(0, LIVE_VARS));
			write_reg(CFG_MODE, {31'($urandom), mode_sel});
			write_reg(CFG_SIZE, {25'($urandom), size_sel});
			write_reg(CFG_OFFSET, rand_q16());
			span = (size_sel == 0) ? LIVE_VARS : size_sel;
			for (int k = 0; k < 14; k++) begin
				pick = $urandom_range(0, 99);
				op = (pick < 35) ? OP_WRITE_WEIGHT : (pick < 50) ? OP_WRITE_BIAS
					: (pick < 94) ? OP_EVALUATE : OP_UNUSED;
				case ($urandom_range(0, 7))
					0: begin
						sol = '1;
					end
					1: begin
						sol = '0;
					end
					default: begin
						sol = {$urandom, $urandom};
					end
				endcase
				push_request(op,
					ROW_W'(($urandom_range(0, 9) < 6) ? $urandom_range(0, span - 1)
						: $urandom_range(0, 63)),
					COL_W'(($urandom_range(0, 9) < 6) ? $urandom_range(0, span - 1)
						: $urandom_range(0, 63)),
					rand_q16(), sol, (k == 7) || ($urandom_range(0, 19) == 0));
			end
			drain_and_wait();
		end

		$display("Run covered %0d weight loads, %0d bias loads and %0d ignored requests,",
			weight_loads, bias_loads, ignored_requests);
		$display("and %0d energy evaluations (%0d Ising) over %0d configuration phases.",
			evaluations, ising_evaluations, phases);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
